[rtl/core/hce_pkg.sv]
`default_nettype none
package hce_pkg;

  // Sizes
  localparam int MAX_DIM = 4;
  localparam int IDX_W   = 2;
  localparam int VAL_W   = 5;
  localparam int SIZE_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 20;
  localparam int ACC_W   = 12;
  localparam int Q_W     = 8;
  localparam int CFG_ADDR_W = 3;

  // Letter range
  localparam logic [CHAR_W-1:0] LETTER_FIRST = 8'h41;
  localparam logic [CHAR_W-1:0] LETTER_LAST  = 8'h5A;

  // Mod 26 by reciprocal: floor(acc * 2521 / 2^16) is exact for acc < 4096
  localparam logic [ACC_W-1:0] MODULUS     = 12'd26;
  localparam logic [ACC_W-1:0] RECIP       = 12'd2521;
  localparam int               RECIP_SHIFT = 16;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_SIZE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_ROW_0 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_ROW_1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_ROW_2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_ROW_3 = 3'd4;

  // Block queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef logic [MAX_DIM-1:0][ROW_W-1:0] key_rows_t;

  // One full (or zero-padded) block handed from front to back
  typedef struct packed {
    logic [SIZE_W-1:0]                size;
    logic [MAX_DIM-1:0][VAL_W-1:0]    vals;
  } block_t;

  // Clamp the raw key size to 1..MAX_DIM
  function automatic logic [SIZE_W-1:0] active_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] s;
    s = raw;
    if (s == '0) s = SIZE_W'(1);
    if (s > SIZE_W'(MAX_DIM)) s = SIZE_W'(MAX_DIM);
    return s;
  endfunction

endpackage
`default_nettype wire

[rtl/core/hce_front.sv]
`default_nettype none
module hce_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clear,
  input  wire logic [hce_pkg::SIZE_W-1:0] size,
  input  wire logic                      in_valid,
  input  wire logic [hce_pkg::CHAR_W-1:0] in_char,
  input  wire logic                      in_eot,
  output logic                           in_ready,
  output logic                           push,
  output hce_pkg::block_t                push_data,
  input  wire logic                      q_full
);
  import hce_pkg::*;

  logic [SIZE_W-1:0]             fill_r, fill_nxt;
  logic [MAX_DIM-1:0][VAL_W-1:0] buf_r;
  logic                          accept, is_letter, emit;
  logic [VAL_W-1:0]              letter_val;
  logic [SIZE_W-1:0]             new_fill;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  // Classify the byte
  assign is_letter  = (in_char >= LETTER_FIRST) && (in_char <= LETTER_LAST);
  assign letter_val = VAL_W'(in_char - LETTER_FIRST);
  assign new_fill   = fill_r + SIZE_W'(is_letter);

  // Block full, or end of text with letters pending
  assign emit = (is_letter && (new_fill >= size)) || (in_eot && (new_fill != '0));
  assign push = accept && emit;

  // Assemble block; positions past the fill read as zero padding
  always_comb begin
    push_data.size = size;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (SIZE_W'(j) >= new_fill) begin
        push_data.vals[j] = '0;
      end else if (is_letter && (SIZE_W'(j) == fill_r)) begin
        push_data.vals[j] = letter_val;
      end else begin
        push_data.vals[j] = buf_r[j];
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (clear) begin
      fill_nxt = '0;
    end else if (accept) begin
      fill_nxt = emit ? '0 : new_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Letter store, no reset
  always_ff @(posedge clk) begin
    if (accept && is_letter) begin
      buf_r[fill_r[IDX_W-1:0]] <= letter_val;
    end
  end

endmodule
`default_nettype wire

[rtl/core/hce_queue.sv]
`default_nettype none
module hce_queue (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire hce_pkg::block_t push_data,
  output logic        full,
  input  wire logic   pop,
  output hce_pkg::block_t pop_data,
  output logic        not_empty
);
  import hce_pkg::*;

  block_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

[rtl/core/hce_back.sv]
`default_nettype none
module hce_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire hce_pkg::key_rows_t       key_rows,
  input  wire logic                     q_valid,
  input  wire hce_pkg::block_t          q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  output logic [hce_pkg::VAL_W-1:0]     out_value,
  output logic                          out_last,
  input  wire logic                     out_ready
);
  import hce_pkg::*;

  // Current block and row under issue
  logic              cur_valid_r;
  block_t            cur_blk_r;
  logic [IDX_W-1:0]  row_r;
  logic              adv, issue, last_row, load;

  // Stage 1: dot product; stage 2: quotient; output register
  logic                  s1_valid_r, s1_last_r;
  logic [ACC_W-1:0]      s1_acc_r, dot;
  logic                  s2_valid_r, s2_last_r;
  logic [ACC_W-1:0]      s2_acc_r;
  logic [Q_W-1:0]        s2_q_r;
  logic [2*ACC_W-1:0]    prod;
  logic [ACC_W-1:0]      rem;
  logic                  out_valid_r, out_last_r;
  logic [VAL_W-1:0]      out_value_r;
  logic [ROW_W-1:0]      row_sel;

  // Whole pipe moves when the output slot is free or being taken
  assign adv      = !out_valid_r || out_ready;
  assign issue    = adv && cur_valid_r;
  assign last_row = ({1'b0, row_r} == SIZE_W'(cur_blk_r.size - SIZE_W'(1)));
  assign load     = !cur_valid_r || (issue && last_row);
  assign q_pop    = load && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      row_r       <= '0;
    end else if (load) begin
      cur_valid_r <= q_valid;
      row_r       <= '0;
    end else if (issue) begin
      row_r <= row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_blk_r <= q_data;
  end

  // Row times block
  assign row_sel = key_rows[row_r];
  always_comb begin
    dot = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      dot = dot + ACC_W'(row_sel[j*VAL_W +: VAL_W]) * ACC_W'(cur_blk_r.vals[j]);
    end
  end

  // Reduce mod 26 from the registered quotient
  assign prod = s1_acc_r * RECIP;
  assign rem  = s2_acc_r - ACC_W'(s2_q_r * MODULUS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= issue;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_acc_r    <= dot;
      s1_last_r   <= last_row;
      s2_acc_r    <= s1_acc_r;
      s2_q_r      <= prod[RECIP_SHIFT +: Q_W];
      s2_last_r   <= s1_last_r;
      out_value_r <= rem[VAL_W-1:0];
      out_last_r  <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

[rtl/core/hill_cipher_encoder_core.sv]
`default_nettype none
// Hill cipher encoder, modulus 26.
// Input stream: one text byte per request on in_tdata, in_tlast marks the
// last byte of the text. Bytes outside 'A'..'Z' are dropped; letters are
// gathered into blocks of key_size values (end of text zero-pads a partial
// block). Output stream: one cipher value 0..25 per request on out_tdata,
// out_tlast set on the last value of each block.
// Configuration: cfg_we with cfg_addr 0 = key_size, 1..4 = key rows 0..3;
// write only while idle. Writing key_size drops a partial block.
// Throughput: one input byte per cycle while the block queue has room; the
// back end emits one value per cycle while out_tready is high, one dot
// product of a key row with the block, so input also stalls when blocks
// arrive faster than the back end drains them (short padded blocks at end of text).
// Path: a completing byte passes the queue, the current block register,
// dot product, quotient and remainder into the output register.
// Reset: key is the identity of size 1, no block pending, queue empty.
// A stalled receiver freezes the back pipeline; the front keeps taking
// bytes until the two-entry block queue fills.
module hill_cipher_encoder_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [7:0] in_char
  input  wire logic                          in_tlast,   // end_of_text
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,  // [4:0] cipher_value, [7:5] zero
  output logic                               out_tlast,  // last_of_block
  input  wire logic                          cfg_we,
  input  wire logic [hce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [hce_pkg::ROW_W-1:0]      cfg_wdata
);
  import hce_pkg::*;

  logic [SIZE_W-1:0] key_size_r;
  key_rows_t         key_rows_r;
  logic              size_wr;
  logic              push, q_full, q_pop, q_valid;
  block_t            push_data, q_data;
  logic [VAL_W-1:0]  cipher_value;

  // Configuration registers
  assign size_wr = cfg_we && (cfg_addr == CFG_KEY_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r    <= SIZE_W'(1);
      key_rows_r[0] <= ROW_W'(1);
      key_rows_r[1] <= ROW_W'(32);
      key_rows_r[2] <= ROW_W'(1024);
      key_rows_r[3] <= ROW_W'(32768);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEY_SIZE:  key_size_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_KEY_ROW_0: key_rows_r[0] <= cfg_wdata;
        CFG_KEY_ROW_1: key_rows_r[1] <= cfg_wdata;
        CFG_KEY_ROW_2: key_rows_r[2] <= cfg_wdata;
        CFG_KEY_ROW_3: key_rows_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (size_wr),
    .size      (active_size(key_size_r)),
    .in_valid  (in_tvalid),
    .in_char   (in_tdata),
    .in_eot    (in_tlast),
    .in_ready  (in_tready),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  hce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  hce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_rows  (key_rows_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_value (cipher_value),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

  assign out_tdata = {(8-VAL_W)'(0), cipher_value};

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench;
  import hce_pkg::*;

  // Register indexes past the key rows; writes to them must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_NONE  = 3'd7;

  // Cycles to let pass after the last value before touching config
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              eot;
  } text_byte_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             last;
  } cipher_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] in_char
  logic                  in_tlast = 1'b0; // end_of_text
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // [4:0] cipher_value, [7:5] zero
  logic                  out_tlast;       // last_of_block
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [ROW_W-1:0]      cfg_wdata = '0;

  hill_cipher_encoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block: key config plus the block being gathered
  logic [SIZE_W-1:0] key_sz = SIZE_W'(1);
  key_rows_t         key_row = {20'd32768, 20'd1024, 20'd32, 20'd1};
  logic [VAL_W-1:0]  blk [MAX_DIM];
  int unsigned       fill_cnt = 0;

  text_byte_t text_q[$];
  cipher_t    cipher_q[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatches = 0;

  // Multiply the gathered (zero-padded) block by the key, push the values
  function automatic void emit_cipher_block(int unsigned sz);
    int unsigned acc;
    cipher_t     c;
    for (int i = 0; i < sz; i++) begin
      acc = 0;
      for (int j = 0; j < sz; j++)
        if (j < fill_cnt) acc += key_row[i][VAL_W*j +: VAL_W] * blk[j];
      c.value = VAL_W'(acc % MODULUS);
      c.last  = (i == sz - 1);
      cipher_q.push_back(c);
    end
    fill_cnt = 0;
  endfunction

  // Expected cipher values caused by one accepted text byte
  function automatic void encipher_byte(logic [CHAR_W-1:0] ch, logic eot);
    int unsigned sz;
    sz = (key_sz == 0) ? 1 : (key_sz > MAX_DIM) ? MAX_DIM : key_sz;
    if (fill_cnt > sz) fill_cnt = 0;
    if (ch >= LETTER_FIRST && ch <= LETTER_LAST) begin
      if (fill_cnt < MAX_DIM) blk[fill_cnt] = VAL_W'(ch - LETTER_FIRST);
      fill_cnt++;
      if (fill_cnt >= sz) begin
        emit_cipher_block(sz);
        return;
      end
    end
    if (eot && fill_cnt > 0) emit_cipher_block(sz);
  endfunction

  // Text driver: predicts on each accepted request, then offers the next byte
  always @(posedge clk) begin : drive_text
    text_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) encipher_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = text_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.ch;
          in_tlast  <= nxt.eot;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Cipher monitor: check each accepted value against the oldest prediction
  always @(posedge clk) begin : watch_cipher
    cipher_t exp_c;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (cipher_q.size() == 0) begin
          $error("cipher_value %0d arrived with nothing predicted", out_tdata[VAL_W-1:0]);
          mismatches++;
        end else begin
          exp_c = cipher_q.pop_front();
          if (out_tdata[VAL_W-1:0] !== exp_c.value) begin
            $error("cipher_value: expected %0d, got %0d", exp_c.value,
                   out_tdata[VAL_W-1:0]);
            mismatches++;
          end
          if (out_tlast !== exp_c.last) begin
            $error("last_of_block: expected %0b, got %0b", exp_c.last, out_tlast);
            mismatches++;
          end
          if (out_tdata[7:VAL_W] !== '0) begin
            $error("tdata padding: expected 0, got %0h", out_tdata[7:VAL_W]);
            mismatches++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send(input logic [CHAR_W-1:0] ch, input logic eot);
    text_byte_t t;
    t.ch  = ch;
    t.eot = eot;
    text_q.push_back(t);
  endtask

  // Wait until every byte is taken and every value is out, then settle
  task automatic wait_idle();
    while (text_q.size() != 0 || in_tvalid || cipher_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the shadow follows at once since the block is idle
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [ROW_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_KEY_SIZE: begin
        key_sz   = data[SIZE_W-1:0];
        fill_cnt = 0;
      end
      CFG_KEY_ROW_0, CFG_KEY_ROW_1, CFG_KEY_ROW_2, CFG_KEY_ROW_3:
        key_row[addr - CFG_KEY_ROW_0] = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [SIZE_W-1:0] sz, input key_rows_t rows);
    cfg_write(CFG_KEY_SIZE, ROW_W'(sz));
    cfg_write(CFG_KEY_ROW_0, rows[0]);
    cfg_write(CFG_KEY_ROW_1, rows[1]);
    cfg_write(CFG_KEY_ROW_2, rows[2]);
    cfg_write(CFG_KEY_ROW_3, rows[3]);
  endtask

  function automatic logic [ROW_W-1:0] pack_row(input int e0, e1, e2, e3);
    return {VAL_W'(e3), VAL_W'(e2), VAL_W'(e1), VAL_W'(e0)};
  endfunction

  // Key row with legal entries, or raw 20-bit noise (entries up to 31)
  function automatic logic [ROW_W-1:0] random_row(input bit raw);
    if (raw) return ROW_W'($urandom_range(20'hFFFFF));
    return pack_row($urandom_range(25), $urandom_range(25),
                    $urandom_range(25), $urandom_range(25));
  endfunction

  initial begin : run
    key_rows_t        rows;
    int               counted;
    logic [CHAR_W-1:0] ch;
    logic             eot;
    logic [SIZE_W-1:0] phase_size [4];

    phase_size = '{SIZE_W'(4), SIZE_W'(2), SIZE_W'(1), SIZE_W'(3)};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity key of size 1: letters pass through, other bytes dropped
    send("A", 1'b0);
    send("Z", 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h40, 1'b0);
    send(8'h5B, 1'b0);
    send("M", 1'b1);     // letter with end of text fills the block, no pad
    send(8'h20, 1'b1);   // end of text on an empty block: nothing out
    wait_idle();

    // Size 3, every key entry 31; stray index writes must not land
    cfg_write(CFG_SPARE, '1);
    cfg_write(CFG_NONE, '1);
    load_key(SIZE_W'(3), {4{20'hFFFFF}});
    send("Z", 1'b0);
    send("Z", 1'b0);
    send("!", 1'b1);     // non-letter end of text flushes the partial block
    send("B", 1'b1);     // letter with end of text, padded
    send("C", 1'b0);
    send("D", 1'b0);
    send("E", 1'b1);
    send("Q", 1'b0);
    send("R", 1'b0);
    wait_idle();
    // Row rewritten mid-block applies when the block goes out
    cfg_write(CFG_KEY_ROW_0, pack_row(1, 2, 3, 4));
    send("S", 1'b0);
    send("T", 1'b0);
    wait_idle();
    // Size 0 acts as 1 and the pending letter is discarded
    cfg_write(CFG_KEY_SIZE, '0);
    send("U", 1'b0);
    wait_idle();

    // Size 7 acts as 4; an all-zero row
    rows[0] = '0;
    for (int r = 1; r < MAX_DIM; r++) rows[r] = random_row(1'b0);
    load_key(SIZE_W'(7), rows);
    send("W", 1'b0);
    send("X", 1'b0);
    send("Y", 1'b0);
    send(8'h80, 1'b1);
    wait_idle();

    // Random text under each idling pattern, new key per pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int r = 0; r < MAX_DIM; r++)
        rows[r] = (p == 1 && r == 0) ? '0 : random_row(p == 3);
      load_key(phase_size[p], rows);
      counted = 0;
      while (counted < 27) begin
        if ($urandom_range(99) < 70) ch = LETTER_FIRST + CHAR_W'($urandom_range(25));
        else ch = CHAR_W'($urandom_range(255));
        eot = ($urandom_range(99) < 8);
        send(ch, eot);
        counted++;
      end
      wait_idle();
    end

    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
